[design/assert_macros.svh]
// Assertion macros shared by the plane distance seed update design.
// Depends on nothing; the including module supplies aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PDSU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PDSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pdsu_pkg.sv]
// Package for the plane distance seed update block: payload types, constants,
// controller states and datapath commands. Depends on nothing.
`default_nettype none

package pdsu_pkg;

    localparam int MAX_TRIANGLES = 65536;
    localparam int SQRT_STEPS    = 34;
    localparam int DIV_STEPS     = 51;
    localparam int CNT_W         = 6;
    localparam logic [15:0] WEIGHT_RESET = 16'd256;
    localparam logic [16:0] ONE_Q8       = 17'd256;

    // Configuration register indexes.
    localparam logic [2:0] REG_PN_X  = 3'd0;
    localparam logic [2:0] REG_PN_Y  = 3'd1;
    localparam logic [2:0] REG_PN_Z  = 3'd2;
    localparam logic [2:0] REG_PC_X  = 3'd3;
    localparam logic [2:0] REG_PC_Y  = 3'd4;
    localparam logic [2:0] REG_PC_Z  = 3'd5;
    localparam logic [2:0] REG_W     = 3'd6;
    localparam logic [2:0] REG_FIRST = 3'd7;

    typedef struct packed {
        logic        [15:0] tri_index;
        logic signed [31:0] tri_normal_x;
        logic signed [31:0] tri_normal_y;
        logic signed [31:0] tri_normal_z;
        logic signed [31:0] tri_center_x;
        logic signed [31:0] tri_center_y;
        logic signed [31:0] tri_center_z;
    } in_item_t;

    typedef struct packed {
        logic [31:0] min_distance;
        logic [47:0] cumulative_sum;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ACC, S_SQRT_INIT, S_SQRT, S_NSAVE, S_MULW,
        S_DIV_INIT, S_DIV, S_MEMRD, S_UPDATE, S_MSQ, S_SUM, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SQ, OP_ACC_SQ, OP_SQRT_INIT, OP_SQRT_STEP,
        OP_NORM_SAVE, OP_MULW, OP_DIV_INIT, OP_DIV_STEP, OP_MEM_RD,
        OP_UPDATE, OP_MSQ, OP_SUM, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] comp;
        logic       sel_center;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

[design/pdsu_ctrl.sv]
// Controller state machine for the plane distance seed update block.
// Depends on pdsu_pkg; drives datapath commands, reads datapath status.
`default_nettype none

module pdsu_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pdsu_pkg::dp_status_t status,
    output pdsu_pkg::dp_cmd_t         cmd
);

    pdsu_pkg::state_t                 state_reg, state_next;
    logic [pdsu_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                             sel_reg, sel_next;

    // State, step counter and norm select registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdsu_pkg::S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    // Next state: two norms (three squares and a root each), then the weight multiply,
    // the divide, the store update, the running sum and the output.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            pdsu_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = pdsu_pkg::S_SQ;
                    cnt_next   = '0;
                    sel_next   = 1'b0;
                end
            end
            pdsu_pkg::S_SQ: state_next = pdsu_pkg::S_ACC;
            pdsu_pkg::S_ACC: begin
                if (cnt_reg == pdsu_pkg::CNT_W'(2)) begin
                    state_next = pdsu_pkg::S_SQRT_INIT;
                end else begin
                    state_next = pdsu_pkg::S_SQ;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            pdsu_pkg::S_SQRT_INIT: begin
                state_next = pdsu_pkg::S_SQRT;
                cnt_next   = '0;
            end
            pdsu_pkg::S_SQRT: begin
                if (cnt_reg == pdsu_pkg::CNT_W'(pdsu_pkg::SQRT_STEPS - 1)) begin
                    state_next = pdsu_pkg::S_NSAVE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pdsu_pkg::S_NSAVE: begin
                if (!sel_reg) begin
                    state_next = pdsu_pkg::S_SQ;
                    sel_next   = 1'b1;
                    cnt_next   = '0;
                end else begin
                    state_next = pdsu_pkg::S_MULW;
                end
            end
            pdsu_pkg::S_MULW: state_next = pdsu_pkg::S_DIV_INIT;
            pdsu_pkg::S_DIV_INIT: begin
                state_next = pdsu_pkg::S_DIV;
                cnt_next   = '0;
            end
            pdsu_pkg::S_DIV: begin
                if (cnt_reg == pdsu_pkg::CNT_W'(pdsu_pkg::DIV_STEPS - 1)) begin
                    state_next = pdsu_pkg::S_MEMRD;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pdsu_pkg::S_MEMRD:  state_next = pdsu_pkg::S_UPDATE;
            pdsu_pkg::S_UPDATE: state_next = pdsu_pkg::S_MSQ;
            pdsu_pkg::S_MSQ:    state_next = pdsu_pkg::S_SUM;
            pdsu_pkg::S_SUM:    state_next = pdsu_pkg::S_OUT;
            pdsu_pkg::S_OUT: begin
                if (!status.out_busy) begin
                    state_next = pdsu_pkg::S_IDLE;
                end
            end
            default: state_next = pdsu_pkg::S_IDLE;
        endcase
    end

    // Command outputs for each state.
    always_comb begin
        cmd.op         = pdsu_pkg::OP_NONE;
        cmd.comp       = cnt_reg[1:0];
        cmd.sel_center = sel_reg;
        s_ready        = 1'b0;
        unique case (state_reg)
            pdsu_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = pdsu_pkg::OP_LOAD;
                end
            end
            pdsu_pkg::S_SQ:        cmd.op = pdsu_pkg::OP_SQ;
            pdsu_pkg::S_ACC:       cmd.op = pdsu_pkg::OP_ACC_SQ;
            pdsu_pkg::S_SQRT_INIT: cmd.op = pdsu_pkg::OP_SQRT_INIT;
            pdsu_pkg::S_SQRT:      cmd.op = pdsu_pkg::OP_SQRT_STEP;
            pdsu_pkg::S_NSAVE:     cmd.op = pdsu_pkg::OP_NORM_SAVE;
            pdsu_pkg::S_MULW:      cmd.op = pdsu_pkg::OP_MULW;
            pdsu_pkg::S_DIV_INIT:  cmd.op = pdsu_pkg::OP_DIV_INIT;
            pdsu_pkg::S_DIV:       cmd.op = pdsu_pkg::OP_DIV_STEP;
            pdsu_pkg::S_MEMRD:     cmd.op = pdsu_pkg::OP_MEM_RD;
            pdsu_pkg::S_UPDATE:    cmd.op = pdsu_pkg::OP_UPDATE;
            pdsu_pkg::S_MSQ:       cmd.op = pdsu_pkg::OP_MSQ;
            pdsu_pkg::S_SUM:       cmd.op = pdsu_pkg::OP_SUM;
            pdsu_pkg::S_OUT: begin
                if (!status.out_busy) begin
                    cmd.op = pdsu_pkg::OP_OUT;
                end
            end
            default: cmd.op = pdsu_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

[design/pdsu_datapath.sv]
// Datapath of the plane distance seed update block: configuration registers,
// shared multiplier, bit-serial root and divider, distance store, running sum.
// Depends on pdsu_pkg.
`default_nettype none

module pdsu_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_wdata,
    input  wire pdsu_pkg::in_item_t   s_item,
    output pdsu_pkg::out_item_t       m_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire pdsu_pkg::dp_cmd_t    cmd,
    output pdsu_pkg::dp_status_t      status
);

    logic [31:0] pn_x_reg, pn_y_reg, pn_z_reg, pc_x_reg, pc_y_reg, pc_z_reg;
    logic [15:0] weight_reg;
    logic        first_reg;

    pdsu_pkg::in_item_t in_reg;
    logic [67:0] prod_reg;
    logic [65:0] sum_reg;
    logic [67:0] rad_reg;
    logic [36:0] rem_reg;
    logic [33:0] root_reg;
    logic [33:0] nn_reg, cn_reg;
    logic [50:0] dvd_reg;
    logic [16:0] drem_reg;
    logic [31:0] rd_reg, m_reg;
    logic [47:0] run_reg;
    pdsu_pkg::out_item_t out_reg;
    logic        out_valid_reg;

    logic [31:0] mem [0:pdsu_pkg::MAX_TRIANGLES-1];

    logic [31:0] t_sel, p_sel;
    logic [32:0] diff, mag;
    logic [33:0] mul_a, mul_b;
    logic [36:0] rem_sh, rem_test;
    logic        root_ge;
    logic [50:0] num;
    logic [16:0] den;
    logic [17:0] div_r;
    logic        div_ge;
    logic [31:0] d_sat;
    logic [47:0] run_base;
    logic [48:0] run_tot;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn_x_reg   <= '0;
            pn_y_reg   <= '0;
            pn_z_reg   <= '0;
            pc_x_reg   <= '0;
            pc_y_reg   <= '0;
            pc_z_reg   <= '0;
            weight_reg <= pdsu_pkg::WEIGHT_RESET;
            first_reg  <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pdsu_pkg::REG_PN_X:  pn_x_reg   <= cfg_wdata;
                pdsu_pkg::REG_PN_Y:  pn_y_reg   <= cfg_wdata;
                pdsu_pkg::REG_PN_Z:  pn_z_reg   <= cfg_wdata;
                pdsu_pkg::REG_PC_X:  pc_x_reg   <= cfg_wdata;
                pdsu_pkg::REG_PC_Y:  pc_y_reg   <= cfg_wdata;
                pdsu_pkg::REG_PC_Z:  pc_z_reg   <= cfg_wdata;
                pdsu_pkg::REG_W:     weight_reg <= cfg_wdata[15:0];
                pdsu_pkg::REG_FIRST: first_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Component selection and exact 33-bit absolute difference.
    always_comb begin
        unique case ({cmd.sel_center, cmd.comp})
            3'b000:  begin t_sel = in_reg.tri_normal_x; p_sel = pn_x_reg; end
            3'b001:  begin t_sel = in_reg.tri_normal_y; p_sel = pn_y_reg; end
            3'b010:  begin t_sel = in_reg.tri_normal_z; p_sel = pn_z_reg; end
            3'b100:  begin t_sel = in_reg.tri_center_x; p_sel = pc_x_reg; end
            3'b101:  begin t_sel = in_reg.tri_center_y; p_sel = pc_y_reg; end
            3'b110:  begin t_sel = in_reg.tri_center_z; p_sel = pc_z_reg; end
            default: begin t_sel = '0;                  p_sel = '0;       end
        endcase
        diff = {t_sel[31], t_sel} - {p_sel[31], p_sel};
        mag  = diff[32] ? (~diff + 33'd1) : diff;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (cmd.op)
            pdsu_pkg::OP_MULW: begin
                mul_a = {18'd0, weight_reg};
                mul_b = cn_reg;
            end
            pdsu_pkg::OP_MSQ: begin
                mul_a = {2'd0, m_reg};
                mul_b = {2'd0, m_reg};
            end
            default: begin
                mul_a = {1'b0, mag};
                mul_b = {1'b0, mag};
            end
        endcase
    end

    // One root bit per step: compare the shifted remainder with 4*root+1.
    always_comb begin
        rem_sh   = {rem_reg[34:0], rad_reg[67:66]};
        rem_test = {1'b0, root_reg, 2'b01};
        root_ge  = (rem_sh >= rem_test);
    end

    // Restoring division, one quotient bit per step.
    always_comb begin
        num    = {9'd0, nn_reg, 8'd0} + prod_reg[50:0];
        den    = pdsu_pkg::ONE_Q8 + {1'b0, weight_reg};
        div_r  = {drem_reg, dvd_reg[50]};
        div_ge = (div_r >= {1'b0, den});
        d_sat  = (|dvd_reg[50:32]) ? 32'hFFFF_FFFF : dvd_reg[31:0];
    end

    // Saturating running sum; index zero restarts it.
    always_comb begin
        run_base = (in_reg.tri_index == 16'd0) ? 48'd0 : run_reg;
        run_tot  = {1'b0, run_base} + {1'b0, prod_reg[63:16]};
    end

    // Working registers, stepped by the controller's commands.
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            pdsu_pkg::OP_LOAD: begin
                in_reg  <= s_item;
                sum_reg <= '0;
            end
            pdsu_pkg::OP_SQ, pdsu_pkg::OP_MULW, pdsu_pkg::OP_MSQ: begin
                prod_reg <= mul_a * mul_b;
            end
            pdsu_pkg::OP_ACC_SQ: sum_reg <= sum_reg + prod_reg[65:0];
            pdsu_pkg::OP_SQRT_INIT: begin
                rad_reg  <= {2'd0, sum_reg};
                rem_reg  <= '0;
                root_reg <= '0;
                sum_reg  <= '0;
            end
            pdsu_pkg::OP_SQRT_STEP: begin
                rad_reg  <= {rad_reg[65:0], 2'd0};
                rem_reg  <= root_ge ? (rem_sh - rem_test) : rem_sh;
                root_reg <= {root_reg[32:0], root_ge};
            end
            pdsu_pkg::OP_NORM_SAVE: begin
                if (cmd.sel_center) begin
                    cn_reg <= root_reg;
                end else begin
                    nn_reg <= root_reg;
                end
            end
            pdsu_pkg::OP_DIV_INIT: begin
                dvd_reg  <= num;
                drem_reg <= '0;
            end
            pdsu_pkg::OP_DIV_STEP: begin
                drem_reg <= div_ge ? 17'(div_r - {1'b0, den}) : div_r[16:0];
                dvd_reg  <= {dvd_reg[49:0], div_ge};
            end
            pdsu_pkg::OP_MEM_RD: rd_reg <= mem[in_reg.tri_index];
            pdsu_pkg::OP_UPDATE: begin
                if (first_reg || (d_sat < rd_reg)) begin
                    mem[in_reg.tri_index] <= d_sat;
                    m_reg <= d_sat;
                end else begin
                    m_reg <= rd_reg;
                end
            end
            pdsu_pkg::OP_OUT: begin
                out_reg.min_distance   <= m_reg;
                out_reg.cumulative_sum <= run_reg;
            end
            default: ;
        endcase
    end

    // Running sum is state with a defined reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
        end else if (cmd.op == pdsu_pkg::OP_SUM) begin
            run_reg <= run_tot[48] ? 48'hFFFF_FFFF_FFFF : run_tot[47:0];
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == pdsu_pkg::OP_OUT) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_item          = out_reg;
    assign m_valid         = out_valid_reg;
    assign status.out_busy = out_valid_reg && !m_ready;

endmodule

`default_nettype wire

[design/plane_distance_seed_update_unit.sv]
// A request is worked through before the next is accepted; the work is mostly in
// the bit-serial square root (34 steps per norm, run twice) and 51-step divider.
// The next request is taken while the previous result waits in the output
// register. Reset: aresetn synchronous, active low; clears the control state,
// configuration, running sum and output valid flag; working registers are not.
// The distance store holds no reset value and must be written before it is read.
`default_nettype none

`include "assert_macros.svh"

module plane_distance_seed_update_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pdsu_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output pdsu_pkg::out_item_t      m_item
);

    pdsu_pkg::dp_cmd_t    cmd;
    pdsu_pkg::dp_status_t status;

    // Sequencer.
    pdsu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic, store and output register.
    pdsu_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_item    (s_item),
        .m_item    (m_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // A request is only loaded on an accept, and the block is busy afterward.
    `PDSU_ASSERT_SAME(a_load_on_accept, cmd.op == pdsu_pkg::OP_LOAD, s_valid && s_ready, "load without accept")
    `PDSU_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready right after accept")
    // The output register is never overwritten while holding an untaken result.
    `PDSU_ASSERT_SAME(a_no_overwrite, cmd.op == pdsu_pkg::OP_OUT, !m_valid || m_ready, "result overwritten")

endmodule

`default_nettype wire
